// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the NEES core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that holds at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/nees_pkg.sv =====
package nees_pkg;

	localparam int VW = 62;
	localparam logic [63:0] LIM_C = 64'h1000_0000_0000_0000;
	localparam logic [31:0] OUT_MAX = 32'hFFFF_FFFF;
	localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

	localparam logic [1:0] REG_SINGLE = 2'd0;
	localparam logic [1:0] REG_COMP = 2'd1;
	localparam logic [1:0] REG_RUNLEN = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SETUP, ST_MUL, ST_DIVCHK, ST_DIV, ST_WB, ST_SUM, ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_D1, OP_S, OP_T, OP_D2, OP_Z1, OP_Z2A, OP_Z2B,
		OP_TA, OP_TB, OP_TC, OP_SGL, OP_MEAN
	} op_t;

	// Clamp a difference to plus or minus 2^60.
	function automatic logic signed [VW-1:0] clamp_lim(input logic signed [VW:0] x);
		logic signed [VW:0] lim;
		lim = $signed({3'b000, LIM_C[59:0]}) + $signed(63'sh1000_0000_0000_0000);
		lim = 63'sh1000_0000_0000_0000;
		if (x > lim)
			return VW'(lim);
		else if (x < -lim)
			return VW'(-lim);
		else
			return VW'(x);
	endfunction

endpackage

// ===== rtl/nees_consistency_metric_3d_core.sv =====
// NEES consistency metric over a 3-vector. Each accepted word carries truth, estimate and the
// lower triangle of the covariance; the block forms e = truth - estimate and returns e'P^-1 e
// (unpivoted LDL' solve) or, in single-component mode, e_k^2 / P_kk, plus the run mean on the
// last word of each run. Every ratio goes through one shared unit: a 32x32 multiplier used four
// times for the product, then a 64-step restoring divider, whose steps are skipped when the
// quotient overflows. A full item takes at most ten ratios, a single-component item one, and
// the run mean adds one more ratio on the last word of a run. in_stall is high while an item
// is being worked or waits for the output register; a finished word waits in the output
// register while the next item is taken.
`include "assert_macros.svh"

module nees_consistency_metric_3d_core import nees_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [15:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] truth_x,
	input  logic signed [31:0] truth_y,
	input  logic signed [31:0] truth_z,
	input  logic signed [31:0] est_x,
	input  logic signed [31:0] est_y,
	input  logic signed [31:0] est_z,
	input  logic [30:0]        cov_xx,
	input  logic signed [31:0] cov_yx,
	input  logic signed [31:0] cov_zx,
	input  logic [30:0]        cov_yy,
	input  logic signed [31:0] cov_zy,
	input  logic [30:0]        cov_zz,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        sample_nees,
	output logic [31:0]        run_mean_nees,
	output logic               run_end,
	output logic               not_positive_definite,
	output logic               value_saturated
);

	state_t state_q, state_d;
	op_t    op_q;

	logic        single_q;
	logic [1:0]  comp_q;
	logic [15:0] run_length_q;
	logic [47:0] sum_q;
	logic [15:0] cnt_q;

	logic signed [32:0] e0_q, e1_q, e2_q, ek_q;
	logic signed [31:0] pyx_q, pzx_q, pzy_q;
	logic [30:0]        dg0_q, dg1_q, dg2_q, dgk_q;
	logic signed [VW-1:0] d1_q, s_q, d2_q, z1_q, z2_q;
	logic [62:0]        tot_q;
	logic               npd_q, end_q;
	logic [31:0]        mean_q;

	logic [60:0]  ua_q, ub_q, c_q, rem_q;
	logic         neg_q;
	logic [2:0]   mc_q;
	logic [63:0]  prod_q, lo_q, q_q;
	logic [120:0] acc_q;
	logic [5:0]   div_cnt_q;

	logic               out_valid_q, run_end_q, npd_out_q, sat_out_q;
	logic [31:0]        sample_out_q, mean_out_q;

	logic signed [VW-1:0] a_m, b_m, base_m;
	logic [60:0]          c_m;
	logic                 in_acc, out_free;

	// Operand selection for the current step of the solve.
	always_comb begin
		a_m = '0;
		b_m = '0;
		c_m = '0;
		base_m = '0;
		case (op_q)
			OP_D1: begin
				a_m = VW'(pyx_q); b_m = VW'(pyx_q); c_m = 61'(dg0_q); base_m = VW'($signed({1'b0, dg1_q}));
			end
			OP_S: begin
				a_m = VW'(pyx_q); b_m = VW'(pzx_q); c_m = 61'(dg0_q); base_m = VW'(pzy_q);
			end
			OP_T: begin
				a_m = VW'(pzx_q); b_m = VW'(pzx_q); c_m = 61'(dg0_q); base_m = VW'($signed({1'b0, dg2_q}));
			end
			OP_D2: begin
				a_m = s_q; b_m = s_q; c_m = d1_q[60:0]; base_m = d2_q;
			end
			OP_Z1: begin
				a_m = VW'(pyx_q); b_m = VW'(e0_q); c_m = 61'(dg0_q); base_m = VW'(e1_q);
			end
			OP_Z2A: begin
				a_m = VW'(pzx_q); b_m = VW'(e0_q); c_m = 61'(dg0_q); base_m = VW'(e2_q);
			end
			OP_Z2B: begin
				a_m = s_q; b_m = z1_q; c_m = d1_q[60:0]; base_m = z2_q;
			end
			OP_TA: begin
				a_m = VW'(e0_q); b_m = VW'(e0_q); c_m = 61'(dg0_q);
			end
			OP_TB: begin
				a_m = z1_q; b_m = z1_q; c_m = d1_q[60:0];
			end
			OP_TC: begin
				a_m = z2_q; b_m = z2_q; c_m = d2_q[60:0];
			end
			OP_SGL: begin
				a_m = VW'(ek_q); b_m = VW'(ek_q); c_m = 61'(dgk_q);
			end
			OP_MEAN: begin
				a_m = VW'($signed({1'b0, sum_q})); b_m = VW'(1); c_m = 61'(cnt_q);
			end
			default: ;
		endcase
	end

	// Division result, clamped and signed, and the value written back.
	logic [60:0]          q_clamped;
	logic signed [VW-1:0] r_w, wb_val;
	always_comb begin
		q_clamped = (q_q > LIM_C) ? LIM_C[60:0] : q_q[60:0];
		r_w = neg_q ? -$signed({1'b0, q_clamped}) : $signed({1'b0, q_clamped});
		wb_val = clamp_lim($signed({base_m[VW-1], base_m}) - $signed({r_w[VW-1], r_w}));
	end

	// End of item bookkeeping.
	logic [31:0] sample_w;
	logic        sat_w, end_w;
	logic [48:0] sum_inc;
	logic [47:0] sum_w;
	logic [16:0] cnt_inc;
	logic [15:0] cnt_w, len_w;
	always_comb begin
		sat_w = npd_q || (tot_q > 63'(OUT_MAX));
		sample_w = sat_w ? OUT_MAX : tot_q[31:0];
		sum_inc = {1'b0, sum_q} + 49'(sample_w);
		sum_w = sum_inc[48] ? SUM_MAX : sum_inc[47:0];
		cnt_inc = {1'b0, cnt_q} + 17'd1;
		cnt_w = cnt_inc[16] ? 16'hFFFF : cnt_inc[15:0];
		len_w = (run_length_q == 16'd0) ? 16'd1 : run_length_q;
		end_w = cnt_w >= len_w;
	end

	logic [61:0] trial;
	logic        trial_ge;
	assign trial = {rem_q, lo_q[63]};
	assign trial_ge = trial >= {1'b0, c_q};

	logic wb_npd;
	assign wb_npd = ((op_q == OP_D1) || (op_q == OP_D2)) && (wb_val <= 0);

	// Control outputs.
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		in_stall = state_q != ST_IDLE;
		in_acc = in_valid && (state_q == ST_IDLE);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SETUP;
			ST_SETUP:  state_d = (c_m == '0) ? ST_SUM : ST_MUL;
			ST_MUL:    if (mc_q == 3'd4) state_d = ST_DIVCHK;
			ST_DIVCHK: state_d = ({4'b0, acc_q[120:64]} >= c_q) ? ST_WB : ST_DIV;
			ST_DIV:    if (div_cnt_q == 6'd63) state_d = ST_WB;
			ST_WB: begin
				if (op_q == OP_MEAN)
					state_d = ST_FIN;
				else if (wb_npd || (op_q == OP_TC) || (op_q == OP_SGL))
					state_d = ST_SUM;
				else
					state_d = ST_SETUP;
			end
			ST_SUM:    state_d = end_w ? ST_SETUP : ST_FIN;
			ST_FIN:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			single_q <= 1'b0;
			comp_q <= 2'd0;
			run_length_q <= 16'd1;
			sum_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			op_q <= OP_D1;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (wr_index)
					REG_SINGLE: single_q <= wr_data[0];
					REG_COMP:   comp_q <= wr_data[1:0];
					REG_RUNLEN: run_length_q <= wr_data;
					default: ;
				endcase
			end
			if (in_acc)
				op_q <= single_q ? OP_SGL : OP_D1;
			if (state_q == ST_WB) begin
				case (op_q)
					OP_D1:   op_q <= OP_S;
					OP_S:    op_q <= OP_T;
					OP_T:    op_q <= OP_D2;
					OP_D2:   op_q <= OP_Z1;
					OP_Z1:   op_q <= OP_Z2A;
					OP_Z2A:  op_q <= OP_Z2B;
					OP_Z2B:  op_q <= OP_TA;
					OP_TA:   op_q <= OP_TB;
					OP_TB:   op_q <= OP_TC;
					OP_MEAN: begin
						sum_q <= '0;
						cnt_q <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_SUM) begin
				sum_q <= sum_w;
				cnt_q <= cnt_w;
				if (end_w)
					op_q <= OP_MEAN;
			end
			if ((state_q == ST_FIN) && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath and the shared multiply-divide unit.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			e0_q <= 33'(truth_x) - 33'(est_x);
			e1_q <= 33'(truth_y) - 33'(est_y);
			e2_q <= 33'(truth_z) - 33'(est_z);
			case (comp_q)
				2'd0: begin
					ek_q <= 33'(truth_x) - 33'(est_x); dgk_q <= cov_xx;
				end
				2'd1: begin
					ek_q <= 33'(truth_y) - 33'(est_y); dgk_q <= cov_yy;
				end
				default: begin
					ek_q <= 33'(truth_z) - 33'(est_z); dgk_q <= cov_zz;
				end
			endcase
			pyx_q <= cov_yx;
			pzx_q <= cov_zx;
			pzy_q <= cov_zy;
			dg0_q <= cov_xx;
			dg1_q <= cov_yy;
			dg2_q <= cov_zz;
			npd_q <= 1'b0;
			tot_q <= '0;
			end_q <= 1'b0;
			mean_q <= '0;
		end
		case (state_q)
			ST_SETUP: begin
				ua_q <= a_m[VW-1] ? 61'(-a_m) : a_m[60:0];
				ub_q <= b_m[VW-1] ? 61'(-b_m) : b_m[60:0];
				neg_q <= a_m[VW-1] ^ b_m[VW-1];
				c_q <= c_m;
				mc_q <= '0;
				acc_q <= '0;
				if (c_m == '0)
					npd_q <= 1'b1;
			end
			ST_MUL: begin
				case (mc_q[1:0])
					2'd0: prod_q <= 64'(ua_q[31:0]) * 64'(ub_q[31:0]);
					2'd1: prod_q <= 64'(ua_q[31:0]) * 64'(ub_q[60:32]);
					2'd2: prod_q <= 64'(ua_q[60:32]) * 64'(ub_q[31:0]);
					default: prod_q <= 64'(ua_q[60:32]) * 64'(ub_q[60:32]);
				endcase
				// The product of the previous cycle is folded in at its weight.
				case (mc_q)
					3'd1:    acc_q <= acc_q + 121'(prod_q);
					3'd2,
					3'd3:    acc_q <= acc_q + (121'(prod_q) << 32);
					3'd4:    acc_q <= acc_q + (121'(prod_q) << 64);
					default: ;
				endcase
				mc_q <= mc_q + 3'd1;
			end
			ST_DIVCHK: begin
				if ({4'b0, acc_q[120:64]} >= c_q) begin
					q_q <= LIM_C;
				end else begin
					rem_q <= 61'(acc_q[120:64]);
					lo_q <= acc_q[63:0];
					q_q <= '0;
					div_cnt_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= trial_ge ? 61'(trial - {1'b0, c_q}) : trial[60:0];
				lo_q <= {lo_q[62:0], 1'b0};
				q_q <= {q_q[62:0], trial_ge};
				div_cnt_q <= div_cnt_q + 6'd1;
			end
			ST_WB: begin
				case (op_q)
					OP_D1: begin
						d1_q <= wb_val;
						if (wb_npd) npd_q <= 1'b1;
					end
					OP_S:   s_q <= wb_val;
					OP_T:   d2_q <= wb_val;
					OP_D2: begin
						d2_q <= wb_val;
						if (wb_npd) npd_q <= 1'b1;
					end
					OP_Z1:  z1_q <= wb_val;
					OP_Z2A: z2_q <= wb_val;
					OP_Z2B: z2_q <= wb_val;
					OP_TA,
					OP_SGL: tot_q <= 63'(q_clamped);
					OP_TB,
					OP_TC:  tot_q <= tot_q + 63'(q_clamped);
					OP_MEAN: mean_q <= (q_clamped > 61'(OUT_MAX)) ? OUT_MAX : q_clamped[31:0];
					default: ;
				endcase
			end
			ST_SUM: begin
				sample_out_q <= sample_w;
				sat_out_q <= sat_w;
				end_q <= end_w;
			end
			ST_FIN: begin
				if (out_free) begin
					run_end_q <= end_q;
					mean_out_q <= end_q ? mean_q : 32'd0;
					npd_out_q <= npd_q;
				end
			end
			default: ;
		endcase
	end

	// The sample fields were settled in ST_SUM and are copied out with the rest.
	logic [31:0] sample_hold_q;
	logic        sat_hold_q;
	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			sample_hold_q <= sample_out_q;
			sat_hold_q <= sat_out_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sample_nees = sample_hold_q;
	assign run_mean_nees = mean_out_q;
	assign run_end = run_end_q;
	assign not_positive_definite = npd_out_q;
	assign value_saturated = sat_hold_q;

	`ASSERT_IMPLIES(a_div_rem, clk, arst_n, state_q == ST_DIV, rem_q < c_q, "remainder not below divisor")
	`ASSERT_IMPLIES(a_npd_sat, clk, arst_n, out_valid && not_positive_definite, value_saturated && (sample_nees == OUT_MAX), "npd word not saturated")
	`ASSERT_IMPLIES(a_mean_zero, clk, arst_n, out_valid && !run_end, run_mean_nees == 32'd0, "mean set outside run end")
	`ASSERT_IMPLIES(a_setup_c, clk, arst_n, (state_q == ST_MUL) || (state_q == ST_DIV), c_q != '0, "divide by zero reached the unit")

endmodule
